>>> rtl/bqc_pkg.sv
// ----------------------------------------------------------------------------
// bqc_pkg
// Shared types and constants for the cascaded biquad band-pass unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bqc_pkg;

    // Filter geometry
    localparam int STAGES      = 3;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 18;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_REGS    = 5;

    localparam int STAGE_BITS   = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int CFG_BITS     = COEF_BITS * STAGES;
    localparam int REG_IDX_BITS = $clog2(NUM_REGS);
    localparam int PROD_BITS    = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_BITS     = PROD_BITS + 3;

    localparam logic [STAGE_BITS-1:0] LAST_STAGE = STAGE_BITS'(STAGES - 1);

    // Coefficient register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_B0 = REG_IDX_BITS'(0);
    localparam logic [REG_IDX_BITS-1:0] REG_B1 = REG_IDX_BITS'(1);
    localparam logic [REG_IDX_BITS-1:0] REG_B2 = REG_IDX_BITS'(2);
    localparam logic [REG_IDX_BITS-1:0] REG_A1 = REG_IDX_BITS'(3);
    localparam logic [REG_IDX_BITS-1:0] REG_A2 = REG_IDX_BITS'(4);

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Multiply order within a stage: history taps first, new input last
    typedef enum logic [2:0] {
        TAP_X1,
        TAP_X2,
        TAP_Y1,
        TAP_Y2,
        TAP_X0
    } tap_t;

    // One delay-line row per stage
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x1;
        logic signed [SAMPLE_BITS-1:0] x2;
        logic signed [SAMPLE_BITS-1:0] y1;
        logic signed [SAMPLE_BITS-1:0] y2;
    } hist_row_t;

    // Sequencer to MAC: tags of the product issued this cycle
    typedef struct packed {
        logic                  vld;
        logic                  first;
        logic                  last;
        logic                  sub;
        logic [STAGE_BITS-1:0] stage;
    } mac_issue_t;

    // MAC to sequencer: finished stage output
    typedef struct packed {
        logic                          done;
        logic [STAGE_BITS-1:0]         stage;
        logic signed [SAMPLE_BITS-1:0] y;
        logic                          sat;
    } mac_result_t;

endpackage

`default_nettype wire

>>> rtl/bqc_mac.sv
// ----------------------------------------------------------------------------
// bqc_mac
// Shared multiply-accumulate for all biquad taps, with round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module bqc_mac (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire bqc_pkg::mac_issue_t                   issue,
    input  wire logic signed [bqc_pkg::COEF_BITS-1:0]  coef,
    input  wire logic signed [bqc_pkg::SAMPLE_BITS-1:0] operand,
    input  wire logic                                  hold,
    output bqc_pkg::mac_result_t                       result
);
    import bqc_pkg::*;

    localparam int Q_BITS = ACC_BITS - FRAC_BITS;
    localparam logic signed [Q_BITS-1:0] Q_MAX = Q_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_BITS-1:0] Q_MIN = -Q_MAX - Q_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

    logic signed [PROD_BITS-1:0] prod_reg;
    logic                        prod_vld_reg;
    logic                        prod_first_reg;
    logic                        prod_last_reg;
    logic                        prod_sub_reg;
    logic [STAGE_BITS-1:0]       prod_stage_reg;

    logic signed [ACC_BITS-1:0]  acc_reg;
    logic signed [ACC_BITS-1:0]  acc_next;
    logic signed [ACC_BITS-1:0]  acc_base;
    logic                        done_reg;
    logic [STAGE_BITS-1:0]       done_stage_reg;

    logic signed [ACC_BITS-1:0]  rounded;
    logic signed [Q_BITS-1:0]    quot;

    // Product register
    always_ff @(posedge clk)
    begin
        prod_reg       <= coef * operand;
        prod_first_reg <= issue.first;
        prod_last_reg  <= issue.last;
        prod_sub_reg   <= issue.sub;
        prod_stage_reg <= issue.stage;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= issue.vld;
        end
    end

    // Accumulate: first tap of a stage restarts the sum, feedback taps subtract
    always_comb
    begin
        acc_base = prod_first_reg ? '0 : acc_reg;
        if (prod_sub_reg)
        begin
            acc_next = acc_base - ACC_BITS'(prod_reg);
        end
        else
        begin
            acc_next = acc_base + ACC_BITS'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_vld_reg)
        begin
            acc_reg <= acc_next;
        end
        if (prod_vld_reg && prod_last_reg)
        begin
            done_stage_reg <= prod_stage_reg;
        end
    end

    // Stage result stays up while the sequencer holds it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (prod_vld_reg && prod_last_reg) || (done_reg && hold);
        end
    end

    // Round to nearest (ties up) and saturate
    always_comb
    begin
        rounded      = acc_reg + ROUND_HALF;
        quot         = rounded[ACC_BITS-1:FRAC_BITS];
        result.done  = done_reg;
        result.stage = done_stage_reg;
        if (quot > Q_MAX)
        begin
            result.y   = Q_MAX[SAMPLE_BITS-1:0];
            result.sat = 1'b1;
        end
        else if (quot < Q_MIN)
        begin
            result.y   = Q_MIN[SAMPLE_BITS-1:0];
            result.sat = 1'b1;
        end
        else
        begin
            result.y   = quot[SAMPLE_BITS-1:0];
            result.sat = 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/biquad_cascade_bandpass_unit.sv
// A new sample is accepted only after the previous one is in the output register.
// The single shared multiplier does five products per stage, one per cycle,
// and stages overlap in the MAC.
// Reset clears the coefficients, marks every delay-line row as zero and
// empties the output register. A restart sample clears the rows the same way.
// ----------------------------------------------------------------------------
// biquad_cascade_bandpass_unit
// Three Direct Form 1 biquad sections in series, delay lines held in a small
// synchronous RAM, one multiplier shared by all taps.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_cascade_bandpass_unit (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // input stream
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  wire logic [bqc_pkg::SAMPLE_BITS-1:0]        s_axis_tdata,  // [23:0] sample_in
    input  wire logic                                   s_axis_tuser,  // [0] restart
    // output stream
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    output logic [bqc_pkg::SAMPLE_BITS-1:0]             m_axis_tdata,  // [23:0] sample_out
    output logic                                        m_axis_tuser,  // [0] clipped
    // coefficient write channel
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [bqc_pkg::REG_IDX_BITS-1:0]       cfg_index,
    input  wire logic [bqc_pkg::CFG_BITS-1:0]           cfg_data
);
    import bqc_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [CFG_BITS-1:0] coef_reg [NUM_REGS];

    // delay-line RAM and per-row valid bits
    hist_row_t             hist_mem [STAGES];
    hist_row_t             rd_row_reg;
    logic                  rd_valid_reg;
    logic [STAGES-1:0]     row_valid_reg;
    logic                  rd_en;
    logic [STAGE_BITS-1:0] rd_addr;
    hist_row_t             row;

    // issue sequencer
    logic                  issue_on_reg;
    logic [STAGE_BITS-1:0] stage_i_reg;
    tap_t                  tap_reg;
    tap_t                  tap_next;

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] x1_hold_reg;
    logic signed [SAMPLE_BITS-1:0] y1_hold_reg;
    logic                          clip_reg;

    logic [REG_IDX_BITS-1:0]       reg_sel;
    logic [CFG_BITS-1:0]           coef_word;
    logic signed [COEF_BITS-1:0]   coef;
    logic signed [SAMPLE_BITS-1:0] operand;
    mac_issue_t                    issue;
    mac_result_t                   res;

    logic in_fire;
    logic out_fire;
    logic cfg_fire;
    logic res_last;
    logic hold;
    logic w_fire;

    logic [SAMPLE_BITS-1:0] m_data_reg;
    logic                   m_user_reg;
    logic                   m_valid_reg;

    // Handshakes
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid && cfg_ready;

    // Coefficient registers; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_fire && (cfg_index < REG_IDX_BITS'(NUM_REGS)))
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (w_fire && res_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Tap order within a stage
    always_comb
    begin
        unique case (tap_reg)
            TAP_X1:  tap_next = TAP_X2;
            TAP_X2:  tap_next = TAP_Y1;
            TAP_Y1:  tap_next = TAP_Y2;
            TAP_Y2:  tap_next = TAP_X0;
            default: tap_next = TAP_X1;
        endcase
    end

    // Issue counters: stage and tap of the product going into the multiplier
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_on_reg <= 1'b0;
            stage_i_reg  <= '0;
            tap_reg      <= TAP_X1;
        end
        else if (in_fire)
        begin
            issue_on_reg <= 1'b1;
            stage_i_reg  <= '0;
            tap_reg      <= TAP_X1;
        end
        else if (issue_on_reg)
        begin
            tap_reg <= tap_next;
            if (tap_reg == TAP_X0)
            begin
                if (stage_i_reg == LAST_STAGE)
                begin
                    issue_on_reg <= 1'b0;
                end
                else
                begin
                    stage_i_reg <= stage_i_reg + 1'b1;
                end
            end
        end
    end

    // Row reads: stage 0 on the input transfer, next stage during the last tap
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (in_fire)
        begin
            rd_en = 1'b1;
        end
        else if (issue_on_reg && (tap_reg == TAP_X0) && (stage_i_reg != LAST_STAGE))
        begin
            rd_en   = 1'b1;
            rd_addr = stage_i_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row_reg <= hist_mem[rd_addr];
        end
        if (w_fire)
        begin
            hist_mem[res.stage] <= '{x1: x_reg, x2: x1_hold_reg, y1: res.y, y2: y1_hold_reg};
        end
    end

    // A row not written since reset or restart reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr] && !(in_fire && s_axis_tuser);
            end
            if (in_fire && s_axis_tuser)
            begin
                row_valid_reg <= '0;
            end
            else if (w_fire)
            begin
                row_valid_reg[res.stage] <= 1'b1;
            end
        end
    end

    assign row = rd_valid_reg ? rd_row_reg : '0;

    // Operand and coefficient for the current tap
    always_comb
    begin
        unique case (tap_reg)
            TAP_X1:
            begin
                reg_sel = REG_B1;
                operand = row.x1;
            end
            TAP_X2:
            begin
                reg_sel = REG_B2;
                operand = row.x2;
            end
            TAP_Y1:
            begin
                reg_sel = REG_A1;
                operand = row.y1;
            end
            TAP_Y2:
            begin
                reg_sel = REG_A2;
                operand = row.y2;
            end
            default:
            begin
                reg_sel = REG_B0;
                operand = x_reg;
            end
        endcase
        coef_word = coef_reg[reg_sel];
        coef      = coef_word[stage_i_reg * COEF_BITS +: COEF_BITS];
    end

    assign issue.vld   = issue_on_reg;
    assign issue.first = (tap_reg == TAP_X1);
    assign issue.last  = (tap_reg == TAP_X0);
    assign issue.sub   = (tap_reg == TAP_Y1) || (tap_reg == TAP_Y2);
    assign issue.stage = stage_i_reg;

    bqc_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (issue),
        .coef    (coef),
        .operand (operand),
        .hold    (hold),
        .result  (res)
    );

    // Stage write-back; the last stage waits for a free output register
    assign res_last = (res.stage == LAST_STAGE);
    assign hold     = res.done && res_last && m_valid_reg && !m_axis_tready;
    assign w_fire   = res.done && !hold;

    // Old x1/y1 of the row leave the read register before write-back
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg <= s_axis_tdata;
        end
        else if (w_fire)
        begin
            x_reg <= res.y;
        end
        if (issue_on_reg && (tap_reg == TAP_X0))
        begin
            x1_hold_reg <= row.x1;
            y1_hold_reg <= row.y1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            clip_reg <= 1'b0;
        end
        else if (w_fire)
        begin
            clip_reg <= clip_reg || res.sat;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (w_fire && res_last)
        begin
            m_data_reg <= res.y;
            m_user_reg <= clip_reg || res.sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (w_fire && res_last)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // Checks
    a_issue_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        issue_on_reg |-> (state_reg == ST_RUN))
        else $error("multiplier issue outside a running item");

    a_start_stage0: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (issue_on_reg && (stage_i_reg == '0) && (tap_reg == TAP_X1)))
        else $error("item did not start at stage 0");

    a_last_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (res.done && res_last) |-> !issue_on_reg)
        else $error("last stage finished while products still issued");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (w_fire && res_last) |=> (m_axis_tvalid && (state_reg == ST_IDLE)))
        else $error("finished sample not presented");

endmodule

`default_nettype wire
